FILE: hdl/sbph_pkg.sv
package sbph_pkg;

  localparam int unsigned ROW_COUNT_DEF    = 20;
  localparam int unsigned COLUMN_COUNT_DEF = 14;
  localparam int unsigned DECAY_PERIOD_DEF = 3;

  localparam int unsigned BAND_W      = 4;
  localparam int unsigned LEVEL_W     = 10;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned LED_INDEX_W = 9;

  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 40;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam int unsigned FULL_SCALE = 1023;
  localparam int unsigned COLOR_MAX  = 255;

  localparam logic [LEVEL_W-1:0] NOISE_FLOOR_RST = 10'd120;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NOISE_FLOOR = 3'd0,
    CFG_COLOR_MODE  = 3'd1,
    CFG_BAR_RED     = 3'd2,
    CFG_BAR_GREEN   = 3'd3,
    CFG_BAR_BLUE    = 3'd4,
    CFG_PEAK_RED    = 3'd5,
    CFG_PEAK_GREEN  = 3'd6,
    CFG_PEAK_BLUE   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CM_OFF     = 2'd0,
    CM_RAINBOW = 2'd1,
    CM_FIXED   = 2'd2,
    CM_UNUSED  = 2'd3
  } color_mode_e;

endpackage

FILE: hdl/spectrum_bar_peak_hold_render_top.sv
// Each accepted band below COLUMN_COUNT yields ROW_COUNT pixel beats, one per cycle
// unless the output stalls; the pixel emitter sets the pace at which bands are taken.
// A band reaches the output via the lookup, hand-off, emitter and output registers.
// After the last band of every DECAY_PERIOD-th frame the peak memory is swept, one
// entry per cycle, and no band is taken while the sweep runs.
// Reset is asynchronous and active low; it clears all peaks and restores the registers.
module spectrum_bar_peak_hold_render_top #(
  parameter int unsigned ROW_COUNT    = sbph_pkg::ROW_COUNT_DEF,
  parameter int unsigned COLUMN_COUNT = sbph_pkg::COLUMN_COUNT_DEF,
  parameter int unsigned DECAY_PERIOD = sbph_pkg::DECAY_PERIOD_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // band [3:0], level [13:4], zero [15:14]
  input  logic [sbph_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // led_index [8:0], red [16:9], green [24:17], blue [32:25], zero [39:33]
  output logic [sbph_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sbph_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [sbph_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import sbph_pkg::*;

  localparam int unsigned RW = $clog2(ROW_COUNT);
  localparam int unsigned HW = $clog2(ROW_COUNT + 1);
  localparam int unsigned AW = $clog2(COLUMN_COUNT > 1 ? COLUMN_COUNT : 2);
  localparam int unsigned PW = $clog2(DECAY_PERIOD > 1 ? DECAY_PERIOD : 2);
  localparam int unsigned XW = LEVEL_W + HW;
  localparam int unsigned EW = RW + 1;

  localparam int Q        = ROW_COUNT / 4;
  localparam int QD1      = (Q > 1) ? Q - 1 : 1;
  localparam int TOP_SPAN = ROW_COUNT - 3 * Q;

  // Rainbow gradient table, one entry per row.
  logic [COLOR_W-1:0] grad_red   [ROW_COUNT];
  logic [COLOR_W-1:0] grad_green [ROW_COUNT];
  logic [COLOR_W-1:0] grad_blue  [ROW_COUNT];

  for (genvar gr = 0; gr < ROW_COUNT; gr++) begin : g_grad
    localparam int RV = gr;
    localparam int G_FIRST = (RV == 0) ? 0 :
                             ((Q > 1) ? ((RV - 1) * COLOR_MAX) / QD1 : COLOR_MAX);
    localparam int G_RED = (RV <= 2 * Q) ? 0 :
                           (RV <= 3 * Q) ? ((RV - 2 * Q) * COLOR_MAX) / Q : COLOR_MAX;
    localparam int G_GRN = (RV <= Q) ? G_FIRST :
                           (RV <= 3 * Q) ? COLOR_MAX : ((RV - 3 * Q) * COLOR_MAX) / TOP_SPAN;
    localparam int G_BLU = (RV <= Q) ? COLOR_MAX :
                           (RV <= 2 * Q) ? COLOR_MAX - ((RV - Q) * COLOR_MAX) / Q : 0;
    assign grad_red[gr]   = COLOR_W'(G_RED);
    assign grad_green[gr] = COLOR_W'(G_GRN);
    assign grad_blue[gr]  = COLOR_W'(G_BLU);
  end

  // Configuration registers.
  logic [LEVEL_W-1:0] noise_floor_q;
  color_mode_e        color_mode_q;
  logic [COLOR_W-1:0] bar_red_q, bar_green_q, bar_blue_q;
  logic [COLOR_W-1:0] peak_red_q, peak_green_q, peak_blue_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_floor_q <= NOISE_FLOOR_RST;
      color_mode_q  <= CM_RAINBOW;
      bar_red_q     <= '0;
      bar_green_q   <= '0;
      bar_blue_q    <= '0;
      peak_red_q    <= '0;
      peak_green_q  <= '0;
      peak_blue_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_NOISE_FLOOR: noise_floor_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_COLOR_MODE:  color_mode_q  <= color_mode_e'(cfg_data_i[1:0]);
        CFG_BAR_RED:     bar_red_q     <= cfg_data_i[COLOR_W-1:0];
        CFG_BAR_GREEN:   bar_green_q   <= cfg_data_i[COLOR_W-1:0];
        CFG_BAR_BLUE:    bar_blue_q    <= cfg_data_i[COLOR_W-1:0];
        CFG_PEAK_RED:    peak_red_q    <= cfg_data_i[COLOR_W-1:0];
        CFG_PEAK_GREEN:  peak_green_q  <= cfg_data_i[COLOR_W-1:0];
        CFG_PEAK_BLUE:   peak_blue_q   <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input decode and bar height.
  logic [BAND_W-1:0]  in_band;
  logic [LEVEL_W-1:0] in_level, lvl_gated;
  logic [XW-1:0]      scaled;
  logic [HW-1:0]      h_coarse, in_h;
  logic [10:0]        h_rem;
  logic               in_range, in_fire;

  assign in_band   = s_axis_tdata[BAND_W-1:0];
  assign in_level  = s_axis_tdata[BAND_W+LEVEL_W-1:BAND_W];
  assign in_range  = 7'(in_band) < 7'(COLUMN_COUNT);
  assign lvl_gated = (in_level < noise_floor_q) ? '0 : in_level;
  assign scaled    = XW'(lvl_gated) * XW'(ROW_COUNT);
  assign h_coarse  = scaled[XW-1:LEVEL_W];
  assign h_rem     = 11'(scaled[LEVEL_W-1:0]) + 11'(h_coarse);
  assign in_h      = h_coarse + HW'(h_rem >= 11'(FULL_SCALE));

  // Pipeline state.
  logic          s1_v_q, s1_last_q;
  logic [AW-1:0] s1_addr_q;
  logic [HW-1:0] s1_h_q;

  logic                   s2_v_q, s2_black_q, s2_odd_q;
  logic [HW-1:0]          s2_h_q;
  logic [RW-1:0]          s2_mark_q;
  logic [LED_INDEX_W-1:0] s2_base_q;

  logic                   em_v_q, em_black_q, em_odd_q;
  logic [HW-1:0]          em_h_q;
  logic [RW-1:0]          em_mark_q, em_i_q, em_row_q;
  logic [LED_INDEX_W-1:0] em_base_q;

  logic                   out_v_q, out_last_q;
  logic [M_TDATA_W-1:0]   out_data_q;

  logic          sw_rd_q, sw_wb_q;
  logic [AW-1:0] sw_cnt_q, sw_wb_addr_q;
  logic [PW-1:0] phase_q;

  logic [COLUMN_COUNT-1:0] entry_valid_q;
  logic                    rd_valid_q;

  assign s_axis_tready = !s1_v_q && !s2_v_q && !sw_rd_q && !sw_wb_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Peak memory: {peak row, pause flag}.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata, entry;

  assign ram_raddr = sw_rd_q ? sw_cnt_q : AW'(in_band);
  assign entry     = rd_valid_q ? ram_rdata : '0;

  sbph_ram #(
    .WIDTH (EW),
    .DEPTH (COLUMN_COUNT)
  ) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Lookup stage: peak compare and write back.
  logic [RW-1:0]          s1_peak, s1_mark;
  logic [HW-1:0]          s1_hm1;
  logic                   s1_new;
  logic [AW-1:0]          s1_col;
  logic [LED_INDEX_W-1:0] s1_base;
  logic                   decay_start;
  logic [RW-1:0]          dec_row;
  logic [EW-1:0]          dec_entry;

  assign s1_peak = entry[EW-1:1];
  assign s1_hm1  = s1_h_q - HW'(1);
  assign s1_new  = (s1_h_q != '0) && (s1_hm1 > HW'(s1_peak));
  assign s1_mark = s1_new ? RW'(s1_hm1) : s1_peak;
  assign s1_col  = AW'(COLUMN_COUNT - 1) - s1_addr_q;
  assign s1_base = LED_INDEX_W'(s1_col * ROW_COUNT);

  assign decay_start = s1_v_q && s1_last_q && (phase_q == PW'(DECAY_PERIOD - 1));

  assign dec_row   = (entry[0] || s1_peak == '0) ? s1_peak : s1_peak - RW'(1);
  assign dec_entry = {dec_row, 1'b0};

  assign ram_we    = (s1_v_q && s1_new) || sw_wb_q;
  assign ram_waddr = sw_wb_q ? sw_wb_addr_q : s1_addr_q;
  assign ram_wdata = sw_wb_q ? dec_entry : {RW'(s1_hm1), 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      rd_valid_q    <= 1'b0;
    end else begin
      rd_valid_q <= entry_valid_q[ram_raddr];
      if (ram_we) begin
        entry_valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      sw_rd_q      <= 1'b0;
      sw_wb_q      <= 1'b0;
      sw_cnt_q     <= '0;
      sw_wb_addr_q <= '0;
      phase_q      <= '0;
    end else begin
      s1_v_q       <= in_fire && in_range;
      sw_wb_q      <= sw_rd_q;
      sw_wb_addr_q <= sw_cnt_q;
      if (decay_start) begin
        sw_rd_q  <= 1'b1;
        sw_cnt_q <= '0;
      end else if (sw_rd_q) begin
        if (sw_cnt_q == AW'(COLUMN_COUNT - 1)) begin
          sw_rd_q <= 1'b0;
        end else begin
          sw_cnt_q <= sw_cnt_q + AW'(1);
        end
      end
      if (s1_v_q && s1_last_q) begin
        phase_q <= decay_start ? '0 : phase_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q <= AW'(in_band);
      s1_last_q <= 7'(in_band) == 7'(COLUMN_COUNT - 1);
      s1_h_q    <= in_h;
    end
  end

  // Hand-off to the pixel emitter.
  logic em_fire, em_end, em_load;

  assign em_fire = em_v_q && (!out_v_q || m_axis_tready);
  assign em_end  = em_fire && (em_i_q == RW'(ROW_COUNT - 1));
  assign em_load = s2_v_q && (!em_v_q || em_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      em_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_v_q) begin
        s2_v_q <= 1'b1;
      end else if (em_load) begin
        s2_v_q <= 1'b0;
      end
      if (em_load) begin
        em_v_q <= 1'b1;
      end else if (em_end) begin
        em_v_q <= 1'b0;
      end
      if (em_fire) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_h_q     <= s1_h_q;
      s2_mark_q  <= s1_mark;
      s2_black_q <= s1_new;
      s2_odd_q   <= s1_col[0];
      s2_base_q  <= s1_base;
    end
    if (em_load) begin
      em_h_q     <= s2_h_q;
      em_mark_q  <= s2_mark_q;
      em_black_q <= s2_black_q;
      em_odd_q   <= s2_odd_q;
      em_base_q  <= s2_base_q;
      em_i_q     <= '0;
      em_row_q   <= s2_odd_q ? RW'(ROW_COUNT - 1) : '0;
    end else if (em_fire) begin
      em_i_q   <= em_i_q + RW'(1);
      em_row_q <= em_odd_q ? em_row_q - RW'(1) : em_row_q + RW'(1);
    end
  end

  // Pixel color.
  logic [COLOR_W-1:0]     px_red, px_green, px_blue;
  logic [LED_INDEX_W-1:0] px_index;

  assign px_index = em_base_q + LED_INDEX_W'(em_i_q);

  always_comb begin
    px_red   = '0;
    px_green = '0;
    px_blue  = '0;
    if (HW'(em_row_q) < em_h_q) begin
      case (color_mode_q)
        CM_RAINBOW: begin
          px_red   = grad_red[em_row_q];
          px_green = grad_green[em_row_q];
          px_blue  = grad_blue[em_row_q];
        end
        CM_FIXED: begin
          px_red   = bar_red_q;
          px_green = bar_green_q;
          px_blue  = bar_blue_q;
        end
        default: ;
      endcase
    end
    if (em_row_q == em_mark_q) begin
      if (em_black_q) begin
        px_red   = '0;
        px_green = '0;
        px_blue  = '0;
      end else begin
        px_red   = peak_red_q;
        px_green = peak_green_q;
        px_blue  = peak_blue_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_fire) begin
      out_data_q <= M_TDATA_W'({px_blue, px_green, px_red, px_index});
      out_last_q <= em_i_q == RW'(ROW_COUNT - 1);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: hdl/sbph_ram.sv
module sbph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/sbph_checker.sv
module sbph_checker #(
  parameter int unsigned ROW_COUNT = sbph_pkg::ROW_COUNT_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sbph_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tlast
);

  import sbph_pkg::*;

  localparam int unsigned RW = $clog2(ROW_COUNT);

  logic                   beat;
  logic [RW-1:0]          cnt_q;
  logic                   mid_q;
  logic [LED_INDEX_W-1:0] prev_idx_q;

  assign beat = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      mid_q      <= 1'b0;
      prev_idx_q <= '0;
    end else if (beat) begin
      cnt_q      <= m_axis_tlast ? '0 : cnt_q + RW'(1);
      mid_q      <= !m_axis_tlast;
      prev_idx_q <= m_axis_tdata[LED_INDEX_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Stalled output beat changed.");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat |-> (m_axis_tlast == (cnt_q == RW'(ROW_COUNT - 1))))
    else $error("Column end does not fall on its last pixel.");

  a_index_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && mid_q |-> m_axis_tdata[LED_INDEX_W-1:0] == prev_idx_q + LED_INDEX_W'(1))
    else $error("Pixel index does not advance by one within a column.");

endmodule

bind spectrum_bar_peak_hold_render_top sbph_checker #(
  .ROW_COUNT (ROW_COUNT)
) u_sbph_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
